FILE: rtl/core/ccs_pkg.sv
package ccs_pkg;

   localparam int CharWidth = 8;

   localparam logic [CharWidth-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CharWidth-1:0] CH_STAR    = 8'h2A;
   localparam logic [CharWidth-1:0] CH_NEWLINE = 8'h0A;

   // result queue: must hold at least two beats so one byte's worth always fits
   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int CountW    = $clog2(FifoDepth + 1);

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_out;
      logic                 text_done;
      logic                 run_last;
   } rsp_beat_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_beat_type first;
      rsp_beat_type second;
   } push_type;

endpackage

FILE: rtl/core/ccs_if.sv
interface ccs_req_if;
   logic                          valid;
   logic                          ready;
   logic [ccs_pkg::CharWidth-1:0] char_in;
   logic                          end_of_text;

   modport source (output valid, output char_in, output end_of_text, input ready);
   modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface ccs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ccs_pkg::CharWidth-1:0] char_out;
   logic                          text_done;
   logic                          run_last;

   modport source (output valid, output char_out, output text_done, output run_last,
                   input ready);
   modport sink (input valid, input char_out, input text_done, input run_last,
                 output ready);
endinterface

FILE: rtl/core/c_comment_stripper.sv
// C comment stripper: passes source text through with comments removed.
// req_bus carries one text byte per beat (char_in) plus end_of_text on the
// last byte of a text. rsp_bus returns the comment-free bytes (char_out);
// run_last marks the last beat produced by one request beat, text_done the
// last beat of a whole text. A request beat yields zero, one or two
// response beats: a held '/' followed by an ordinary byte gives two.
// A byte taken from req_bus waits in the input holding register; its beats
// go through the result queue to rsp_bus. Throughput: one request beat per
// cycle while each yields at most one response beat and the queue has room;
// the response side drains one beat per cycle, so bytes that yield two beats
// fill it. The four-entry result queue and input holding register set this.
// Reset (synchronous, active high) returns to normal text with nothing held
// and empties the result queue. When the receiver stalls, beats wait in the
// queue; req_bus.ready drops once a byte is held and two more beats cannot fit.
module c_comment_stripper (
   input  logic      clock,
   input  logic      reset,
   ccs_req_if.sink   req_bus,
   ccs_rsp_if.source rsp_bus
);

   ccs_pkg::push_type push;
   logic              room;

   ccs_step u_step (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .room    (room),
      .push    (push)
   );

   ccs_out_fifo u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

FILE: rtl/core/ccs_step.sv
module ccs_step (
   input  logic               clock,
   input  logic               reset,
   ccs_req_if.sink            req_bus,
   input  logic               room,
   output ccs_pkg::push_type  push
);

   logic                          hold_valid_ff;
   logic                          hold_valid_in;
   logic [ccs_pkg::CharWidth-1:0] hold_char_ff;
   logic                          hold_eot_ff;

   ccs_pkg::scan_mode_type mode_ff;
   ccs_pkg::scan_mode_type mode_in;
   logic                   pend_ff;
   logic                   pend_in;
   logic                   star_ff;
   logic                   star_in;
   logic                   nl_ff;
   logic                   nl_in;

   logic                          advance;
   logic                          take;
   logic [ccs_pkg::CharWidth-1:0] c;
   logic                          c_slash;
   logic                          c_star;
   logic                          c_nl;

   assign advance       = hold_valid_ff & room;
   assign req_bus.ready = ~hold_valid_ff | room;
   assign take          = req_bus.valid & req_bus.ready;
   assign hold_valid_in = take | (hold_valid_ff & ~advance);

   assign c       = hold_char_ff;
   assign c_slash = (c == ccs_pkg::CH_SLASH);
   assign c_star  = (c == ccs_pkg::CH_STAR);
   assign c_nl    = (c == ccs_pkg::CH_NEWLINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_char_ff <= req_bus.char_in;
         hold_eot_ff  <= req_bus.end_of_text;
      end
   end

   // next scan state
   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      star_in = star_ff;
      nl_in   = nl_ff;
      case (mode_ff)
         ccs_pkg::MODE_LINE: begin
            if (c_nl) begin
               mode_in = ccs_pkg::MODE_NORMAL;
            end
         end
         ccs_pkg::MODE_BLOCK: begin
            if (star_ff && c_slash) begin
               mode_in = ccs_pkg::MODE_NORMAL;
               star_in = 1'b0;
               nl_in   = 1'b0;
            end else begin
               star_in = c_star;
               nl_in   = nl_ff | c_nl;
            end
         end
         default: begin
            mode_in = ccs_pkg::MODE_NORMAL;
            if (pend_ff) begin
               pend_in = 1'b0;
               if (c_slash) begin
                  mode_in = ccs_pkg::MODE_LINE;
               end else if (c_star) begin
                  mode_in = ccs_pkg::MODE_BLOCK;
                  star_in = 1'b0;
                  nl_in   = 1'b0;
               end
            end else if (c_slash) begin
               pend_in = 1'b1;
            end
         end
      endcase
      // end of text drops any open comment and returns to reset state
      if (hold_eot_ff) begin
         mode_in = ccs_pkg::MODE_NORMAL;
         pend_in = 1'b0;
         star_in = 1'b0;
         nl_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ccs_pkg::MODE_NORMAL;
         pend_ff <= 1'b0;
         star_ff <= 1'b0;
         nl_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         star_ff <= star_in;
         nl_ff   <= nl_in;
      end
   end

   // result beats for the held byte
   always_comb begin
      push              = '0;
      push.first.char_out  = c;
      push.second.char_out = c;
      case (mode_ff)
         ccs_pkg::MODE_LINE: begin
            if (c_nl) begin
               push.count = 2'd1;
            end
         end
         ccs_pkg::MODE_BLOCK: begin
            if (star_ff && c_slash && nl_ff) begin
               push.count          = 2'd1;
               push.first.char_out = ccs_pkg::CH_NEWLINE;
            end
         end
         default: begin
            if (pend_ff) begin
               if (!c_slash && !c_star) begin
                  push.count          = 2'd2;
                  push.first.char_out = ccs_pkg::CH_SLASH;
               end
            end else if (c_slash) begin
               // a slash that ends the text has no lookahead: flush it
               if (hold_eot_ff) begin
                  push.count = 2'd1;
               end
            end else begin
               push.count = 2'd1;
            end
         end
      endcase
      if (!advance) begin
         push.count = 2'd0;
      end
      push.first.run_last   = (push.count == 2'd1);
      push.first.text_done  = hold_eot_ff & (push.count == 2'd1);
      push.second.run_last  = 1'b1;
      push.second.text_done = hold_eot_ff;
   end

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      advance && hold_eot_ff |=> mode_ff == ccs_pkg::MODE_NORMAL && !pend_ff && !star_ff
                                 && !nl_ff)
      else $error("state not cleared after end of text");

   a_star_in_block: assert property (@(posedge clock) disable iff (reset)
      star_ff || nl_ff |-> mode_ff == ccs_pkg::MODE_BLOCK)
      else $error("comment flags set outside block comment");

   a_pend_in_normal: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> mode_ff != ccs_pkg::MODE_LINE && mode_ff != ccs_pkg::MODE_BLOCK)
      else $error("held slash inside a comment");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room && hold_valid_ff)
      else $error("result pushed without queue room");

endmodule

FILE: rtl/core/ccs_out_fifo.sv
module ccs_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  ccs_pkg::push_type push,
   output logic              room,
   ccs_rsp_if.source         rsp_bus
);

   ccs_pkg::rsp_beat_type mem [ccs_pkg::FifoDepth];

   logic [ccs_pkg::FifoAw-1:0] wr_ptr_ff;
   logic [ccs_pkg::FifoAw-1:0] wr_ptr_in;
   logic [ccs_pkg::FifoAw-1:0] wr_next;
   logic [ccs_pkg::FifoAw-1:0] rd_ptr_ff;
   logic [ccs_pkg::FifoAw-1:0] rd_ptr_in;
   logic [ccs_pkg::CountW-1:0] count_ff;
   logic [ccs_pkg::CountW-1:0] count_in;
   logic                       pop;
   ccs_pkg::rsp_beat_type      head;

   assign room    = (count_ff <= ccs_pkg::CountW'(ccs_pkg::FifoDepth - 2));
   assign pop     = rsp_bus.valid & rsp_bus.ready;
   assign wr_next = wr_ptr_ff + ccs_pkg::FifoAw'(1);

   assign wr_ptr_in = wr_ptr_ff + ccs_pkg::FifoAw'(push.count);
   assign rd_ptr_in = rd_ptr_ff + ccs_pkg::FifoAw'(pop);
   assign count_in  = count_ff + ccs_pkg::CountW'(push.count) - ccs_pkg::CountW'(pop);

   assign head              = mem[rd_ptr_ff];
   assign rsp_bus.valid     = (count_ff != '0);
   assign rsp_bus.char_out  = head.char_out;
   assign rsp_bus.text_done = head.text_done;
   assign rsp_bus.run_last  = head.run_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ccs_pkg::CountW'(ccs_pkg::FifoDepth))
      else $error("result queue overflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - ccs_pkg::CountW'(1))
      else $error("queue count lost a beat");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 || count_ff == ccs_pkg::CountW'(ccs_pkg::FifoDepth)
      |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

FILE: tb/sv/tb_c_comment_stripper.sv
`timescale 1ns / 100ps

module tb_c_comment_stripper;

   localparam int CycleLimit  = 200000;
   localparam int PhaseBytes  = 185;
   localparam int DrainCycles = 8;
   localparam int CharW       = ccs_pkg::CharWidth;

   // Mirrors the stripper's scan state and queues the bytes it should emit.
   class comment_scoreboard;
      ccs_pkg::scan_mode_type mode;
      logic                   slash_held;
      logic                   star_prev;
      logic                   block_nl;
      ccs_pkg::rsp_beat_type  pending[$];
      int                     errors;

      function new();
         errors = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         mode       = ccs_pkg::MODE_NORMAL;
         slash_held = 1'b0;
         star_prev  = 1'b0;
         block_nl   = 1'b0;
      endfunction

      function void note_text_byte(logic [CharW-1:0] c, logic eot);
         logic [CharW-1:0]      emit [0:1];
         int                    n;
         ccs_pkg::rsp_beat_type beat;
         n = 0;
         case (mode)
            ccs_pkg::MODE_LINE: begin
               if (c == ccs_pkg::CH_NEWLINE) begin
                  emit[n] = c;
                  n++;
                  mode = ccs_pkg::MODE_NORMAL;
               end
            end
            ccs_pkg::MODE_BLOCK: begin
               if (star_prev && c == ccs_pkg::CH_SLASH) begin
                  if (block_nl) begin
                     emit[n] = ccs_pkg::CH_NEWLINE;
                     n++;
                  end
                  mode      = ccs_pkg::MODE_NORMAL;
                  star_prev = 1'b0;
                  block_nl  = 1'b0;
               end else begin
                  star_prev = (c == ccs_pkg::CH_STAR);
                  if (c == ccs_pkg::CH_NEWLINE) block_nl = 1'b1;
               end
            end
            default: begin
               mode = ccs_pkg::MODE_NORMAL;
               if (slash_held) begin
                  slash_held = 1'b0;
                  if (c == ccs_pkg::CH_SLASH) begin
                     mode = ccs_pkg::MODE_LINE;
                  end else if (c == ccs_pkg::CH_STAR) begin
                     mode      = ccs_pkg::MODE_BLOCK;
                     star_prev = 1'b0;
                     block_nl  = 1'b0;
                  end else begin
                     emit[0] = ccs_pkg::CH_SLASH;
                     emit[1] = c;
                     n = 2;
                  end
               end else if (c == ccs_pkg::CH_SLASH) begin
                  slash_held = 1'b1;
               end else begin
                  emit[n] = c;
                  n++;
               end
            end
         endcase

         if (eot) begin
            // a slash still held at end of text goes out as the final byte
            if (mode == ccs_pkg::MODE_NORMAL && slash_held) begin
               emit[n] = ccs_pkg::CH_SLASH;
               n++;
            end
            clear_scan();
         end

         for (int k = 0; k < n; k++) begin
            beat.char_out  = emit[k];
            beat.run_last  = (k == n - 1);
            beat.text_done = eot && (k == n - 1);
            pending = {pending, beat};
         end
      endfunction

      function void check_output_byte(logic [CharW-1:0] c, logic done, logic last);
         ccs_pkg::rsp_beat_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected output beat char_out=%h text_done=%b run_last=%b",
                     $time, c, done, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.char_out !== c) begin
            $display("%0t: char_out expected %h actual %h", $time, want.char_out, c);
            errors++;
         end
         if (want.text_done !== done) begin
            $display("%0t: text_done expected %b actual %b (char %h)",
                     $time, want.text_done, done, want.char_out);
            errors++;
         end
         if (want.run_last !== last) begin
            $display("%0t: run_last expected %b actual %b (char %h)",
                     $time, want.run_last, last, want.char_out);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   sender_idle_pct = 0;
   int   stall_pct = 0;

   logic [CharW-1:0]  text_bytes[$];
   comment_scoreboard sb;

   ccs_req_if req_bus ();
   ccs_rsp_if rsp_bus ();

   c_comment_stripper u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_text_byte(req_bus.char_in, req_bus.end_of_text);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_output_byte(rsp_bus.char_out, rsp_bus.text_done, rsp_bus.run_last);
      end
   end

   // Slashes, stars and newlines show up often enough to open and close comments.
   function automatic logic [CharW-1:0] biased_byte();
      case ($urandom_range(9))
         0, 1:    return ccs_pkg::CH_SLASH;
         2:       return ccs_pkg::CH_STAR;
         3:       return ccs_pkg::CH_NEWLINE;
         default: return CharW'($urandom_range(255));
      endcase
   endfunction

   function automatic void append_byte(logic [CharW-1:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   function automatic void build_random_text();
      int n_tokens;
      int len;
      n_tokens = $urandom_range(1, 8);
      text_bytes.delete();
      for (int t = 0; t < n_tokens; t++) begin
         case ($urandom_range(9))
            0, 1, 2: append_byte(CharW'($urandom_range(255)));
            3: begin
               append_byte(ccs_pkg::CH_SLASH);
               append_byte(ccs_pkg::CH_SLASH);
               len = $urandom_range(6);
               repeat (len) append_byte(biased_byte());
               // leave some line comments open
               if ($urandom_range(9) < 8) append_byte(ccs_pkg::CH_NEWLINE);
            end
            4, 5: begin
               append_byte(ccs_pkg::CH_SLASH);
               append_byte(ccs_pkg::CH_STAR);
               len = $urandom_range(8);
               repeat (len) append_byte(biased_byte());
               if ($urandom_range(19) < 17) begin
                  append_byte(ccs_pkg::CH_STAR);
                  append_byte(ccs_pkg::CH_SLASH);
               end
            end
            6: append_byte(ccs_pkg::CH_SLASH);
            default: append_byte(biased_byte());
         endcase
      end
   endfunction

   task automatic send_byte(logic [CharW-1:0] c, logic eot);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.char_in     <= c;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic run_phase(int idle_pct, int stall);
      int sent;
      sent            = 0;
      sender_idle_pct = idle_pct;
      stall_pct       = stall;
      while (sent < PhaseBytes) begin
         build_random_text();
         send_text();
         sent += text_bytes.size();
      end
   endtask

   initial begin
      sb                  = new();
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.char_in     = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, held slash before an ordinary byte, held slash at end of text
      text_bytes = '{8'h00, ccs_pkg::CH_SLASH, 8'hFF, ccs_pkg::CH_SLASH};
      send_text();
      // line comment keeps its newline
      text_bytes = '{ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_NEWLINE, 8'h62};
      send_text();
      // slash star slash stays open until a later star slash
      text_bytes = '{ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH,
                     ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH, 8'h7A};
      send_text();
      // block comment spanning a line break closes at end of text
      text_bytes = '{ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_NEWLINE,
                     ccs_pkg::CH_STAR, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH};
      send_text();
      // unterminated block and line comments produce nothing
      text_bytes = '{ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, 8'h61};
      send_text();
      text_bytes = '{ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, 8'h78};
      send_text();
      text_bytes = '{8'h6B};
      send_text();

      run_phase(0, 0);
      run_phase(75, 0);
      run_phase(0, 75);
      run_phase(34, 34);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
